### hdl/dnsqx_pkg.sv
`timescale 1ns / 1ps
// Package for the DNS query name extractor: beat types, decoder command type
// and sizing constants. No dependencies.
package dnsqx_pkg;

  localparam int unsigned NAME_MAX     = 128;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned LABEL_MAX    = 63;
  localparam int unsigned TAIL_BYTES   = 4;
  localparam int unsigned CHAR_CAP     = (NAME_MAX - 1 > 127) ? 127 : NAME_MAX - 1;
  localparam int unsigned POS_W        = $clog2(HEADER_BYTES + NAME_MAX + 1);
  localparam int unsigned NAME_END_POS = HEADER_BYTES + NAME_MAX - 1;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [15:0] txn_id;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [6:0]  name_length;
    logic        end_of_query;
  } out_beat_t;

  typedef struct packed {
    logic        has_char;
    logic        has_sum;
    logic [7:0]  name_char;
    logic [15:0] txn_id;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [6:0]  name_length;
  } cmd_t;

endpackage

### hdl/dnsqx_front.sv
`timescale 1ns / 1ps
// Front end: parses the header, decodes labels and the type/class tail per beat
// and issues at most one command per beat. Depends on dnsqx_pkg.
module dnsqx_front import dnsqx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      txn_q, txn_d;
  logic             resp_q, resp_d;
  logic [5:0]       left_q, left_d;
  logic             first_q, first_d;
  logic             fin_q, fin_d;
  logic [6:0]       chars_q, chars_d;
  logic [2:0]       tail_q, tail_d;
  logic [15:0]      type_q, type_d;
  logic [15:0]      class_q, class_d;
  logic [7:0]       b;

  assign b = beat_i.data_byte;

  always_comb begin
    pos_d   = pos_q;
    txn_d   = txn_q;
    resp_d  = resp_q;
    left_d  = left_q;
    first_d = first_q;
    fin_d   = fin_q;
    chars_d = chars_q;
    tail_d  = tail_q;
    type_d  = type_q;
    class_d = class_q;
    cmd_o   = '0;
    if (accept_i) begin
      if (pos_q < POS_W'(HEADER_BYTES)) begin
        if (pos_q == POS_W'(0)) begin
          txn_d = {b, 8'h00};
        end else if (pos_q == POS_W'(1)) begin
          txn_d = {txn_q[15:8], b};
        end else if (pos_q == POS_W'(2) && b[7]) begin
          resp_d = 1'b1;
        end
      end else if (!resp_q) begin
        if (!fin_q) begin
          if (left_q == 6'd0) begin
            if (b == 8'd0 || b > 8'(LABEL_MAX)) begin
              fin_d = 1'b1;
            end else begin
              left_d = b[5:0];
              if (!first_q && chars_q < 7'(CHAR_CAP)) begin
                cmd_o.has_char  = 1'b1;
                cmd_o.name_char = DOT_CHAR;
                chars_d         = chars_q + 7'd1;
              end
              first_d = 1'b0;
            end
          end else begin
            if (chars_q < 7'(CHAR_CAP)) begin
              cmd_o.has_char  = 1'b1;
              cmd_o.name_char = b;
              chars_d         = chars_q + 7'd1;
            end
            left_d = left_q - 6'd1;
          end
          if (pos_q >= POS_W'(NAME_END_POS)) begin
            fin_d = 1'b1;
          end
        end else if (tail_q < 3'(TAIL_BYTES)) begin
          if (tail_q < 3'd2) begin
            type_d = {type_q[7:0], b};
          end else begin
            class_d = {class_q[7:0], b};
          end
          tail_d = tail_q + 3'd1;
        end
      end
      if (pos_q != '1) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (beat_i.last_byte) begin
        if (pos_d >= POS_W'(HEADER_BYTES) && !resp_d) begin
          cmd_o.has_sum     = 1'b1;
          cmd_o.txn_id      = txn_d;
          cmd_o.query_type  = (tail_d >= 3'(TAIL_BYTES)) ? type_d : 16'd0;
          cmd_o.query_class = (tail_d >= 3'(TAIL_BYTES)) ? class_d : 16'd0;
          cmd_o.name_length = chars_d;
        end
        pos_d   = '0;
        txn_d   = '0;
        resp_d  = 1'b0;
        left_d  = '0;
        first_d = 1'b1;
        fin_d   = 1'b0;
        chars_d = '0;
        tail_d  = '0;
        type_d  = '0;
        class_d = '0;
      end
    end
    cmd_valid_o = cmd_o.has_char || cmd_o.has_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      txn_q   <= '0;
      resp_q  <= 1'b0;
      left_q  <= '0;
      first_q <= 1'b1;
      fin_q   <= 1'b0;
      chars_q <= '0;
      tail_q  <= '0;
      type_q  <= '0;
      class_q <= '0;
    end else begin
      pos_q   <= pos_d;
      txn_q   <= txn_d;
      resp_q  <= resp_d;
      left_q  <= left_d;
      first_q <= first_d;
      fin_q   <= fin_d;
      chars_q <= chars_d;
      tail_q  <= tail_d;
      type_q  <= type_d;
      class_q <= class_d;
    end
  end

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= 7'(CHAR_CAP)) else $error("name character count over cap");
  a_tail_after_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q != 3'd0 |-> fin_q) else $error("tail bytes taken before name end");
  a_label_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q != 6'd0 |-> !first_q) else $error("label open with first pending");

endmodule

### hdl/dnsqx_queue.sv
`timescale 1ns / 1ps
// Command queue between decoder front and output back end, flop based.
// Depends on dnsqx_pkg.
module dnsqx_queue import dnsqx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_pop;

  assign full_o       = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_cmd_o   = mem_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

### hdl/dnsqx_back.sv
`timescale 1ns / 1ps
// Back end: turns queued commands into result beats, character first, then
// summary, through an output register. Depends on dnsqx_pkg.
module dnsqx_back import dnsqx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o,
  input  logic      out_stall_i
);

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;
  logic      char_done_q, char_done_d;
  logic      load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    char_done_d = char_done_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d = '0;
        if (head_cmd_i.has_char && !char_done_q) begin
          out_d.kind      = KIND_CHAR;
          out_d.name_char = head_cmd_i.name_char;
          if (head_cmd_i.has_sum) begin
            char_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_d.kind         = KIND_SUMMARY;
          out_d.txn_id       = head_cmd_i.txn_id;
          out_d.query_type   = head_cmd_i.query_type;
          out_d.query_class  = head_cmd_i.query_class;
          out_d.name_length  = head_cmd_i.name_length;
          out_d.end_of_query = 1'b1;
          char_done_d        = 1'b0;
          pop_o              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
      char_done_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      char_done_q <= char_done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_split_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_done_q |-> head_valid_i && head_cmd_i.has_char && head_cmd_i.has_sum)
    else $error("split command lost its head");

endmodule

### hdl/dns_query_name_extractor.sv
`timescale 1ns / 1ps
// DNS query name extractor top level: front decoder, command queue, back end.
// Path: a result beat passes through the command queue and then the output register; a
// summary sharing its byte with a character follows that character.
// Throughput: one byte per cycle while the command queue is not full; a final byte with a
// character gives two result beats, absorbed by the 4-entry command queue.
// Reset: asynchronous, active low; clears parser state, queue and output valid.
// Depends on dnsqx_pkg, dnsqx_front, dnsqx_queue, dnsqx_back.
module dns_query_name_extractor import dnsqx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dnsqx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .beat_i      (in_beat_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  dnsqx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_valid),
    .push_cmd_i   (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  dnsqx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_beat_o   (out_beat_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

### tb/tb_dns_query_name_extractor.sv
`timescale 1ns / 1ps
// Self-checking testbench for dns_query_name_extractor: directed message table, then random
// DNS messages under three sender/receiver idle mixes, checked against a cycle-free parser
// or typed-row table summaries. Depends on dnsqx_pkg and the dns_query_name_extractor RTL.
module tb_dns_query_name_extractor;
  import dnsqx_pkg::*;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  flags;
    logic [2:0]  nlab;
    logic [5:0]  llen;
    logic [7:0]  term;
    logic [31:0] tail;
    logic [2:0]  tail_len;
    logic [3:0]  extra;
    logic [7:0]  trunc;
    logic        typed;
    logic        has_sum;
    logic [6:0]  sum_len;
  } msg_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  dns_query_name_extractor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always #1 clk_i = ~clk_i;

  // parser state
  logic [15:0] pos;
  logic [15:0] txn;
  logic        resp;
  logic [5:0]  lab_left;
  logic        first_pending;
  logic        name_done;
  logic [6:0]  nchars;
  logic [2:0]  tail_cnt;
  logic [15:0] qtype;
  logic [15:0] qclass;

  out_beat_t  step_beats[$];
  out_beat_t  qname_beats_q[$];
  logic [7:0] msg_bytes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int chars_seen = 0;
  int sums_seen = 0;

  msg_row_t msg_tab [0:18] = '{
    '{16'hFFFF, 8'h00, 3'd0, 6'd0,  8'h00, 32'h0,         3'd0, 4'd0, 8'd1,  1'b1, 1'b0, 7'd0},
    '{16'hFFFF, 8'hFF, 3'd0, 6'd0,  8'h00, 32'h0,         3'd0, 4'd0, 8'd11, 1'b1, 1'b0, 7'd0},
    '{16'hFFFF, 8'h00, 3'd0, 6'd0,  8'h00, 32'h0,         3'd0, 4'd0, 8'd12, 1'b1, 1'b1, 7'd0},
    '{16'h1234, 8'h80, 3'd2, 6'd5,  8'h00, 32'hFFFF_FFFF, 3'd4, 4'd0, 8'd0,  1'b1, 1'b0, 7'd0},
    '{16'h0000, 8'h00, 3'd0, 6'd0,  8'h00, 32'hFFFF_FFFF, 3'd4, 4'd0, 8'd0,  1'b1, 1'b1, 7'd0},
    '{16'h0001, 8'h01, 3'd1, 6'd3,  8'h00, 32'h0001_0001, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'hA55A, 8'h7F, 3'd3, 6'd1,  8'h00, 32'h001C_0001, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h5AA5, 8'h01, 3'd2, 6'd4,  8'hC0, 32'h0005_00FF, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0F0F, 8'h00, 3'd1, 6'd2,  8'd64, 32'h1234_5678, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'hF0F0, 8'h00, 3'd1, 6'd2,  8'hFF, 32'h8765_4321, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0100, 8'h00, 3'd1, 6'd63, 8'h00, 32'h0001_0001, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0200, 8'h00, 3'd2, 6'd63, 8'h00, 32'h00FF_0001, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0300, 8'h00, 3'd3, 6'd63, 8'h00, 32'hABCD_EF01, 3'd4, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0400, 8'h00, 3'd2, 6'd3,  8'h00, 32'h0001_0001, 3'd4, 4'd0, 8'd17, 1'b0, 1'b0, 7'd0},
    '{16'h0500, 8'h00, 3'd1, 6'd4,  8'h00, 32'h0001_0001, 3'd2, 4'd0, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0600, 8'h00, 3'd1, 6'd4,  8'h00, 32'h0001_0001, 3'd4, 4'd5, 8'd0,  1'b0, 1'b0, 7'd0},
    '{16'h0700, 8'h00, 3'd1, 6'd10, 8'h00, 32'h0001_0001, 3'd4, 4'd0, 8'd16, 1'b0, 1'b0, 7'd0},
    '{16'h1234, 8'h00, 3'd0, 6'd0,  8'h00, 32'h0,         3'd0, 4'd0, 8'd0,  1'b1, 1'b1, 7'd0},
    '{16'h8000, 8'h00, 3'd4, 6'd7,  8'h00, 32'h0000_0000, 3'd4, 4'd1, 8'd0,  1'b0, 1'b0, 7'd0}
  };

  function automatic out_beat_t char_beat(input logic [7:0] c);
    out_beat_t ob;
    ob = '0;
    ob.kind = KIND_CHAR;
    ob.name_char = c;
    return ob;
  endfunction

  function automatic string fmt_beat(input out_beat_t ob);
    return $sformatf("kind=%0d char=%h id=%h qt=%h qc=%h len=%0d eoq=%0d", ob.kind,
                     ob.name_char, ob.txn_id, ob.query_type, ob.query_class,
                     ob.name_length, ob.end_of_query);
  endfunction

  task automatic reset_parser();
    pos = '0;
    txn = '0;
    resp = 1'b0;
    lab_left = '0;
    first_pending = 1'b1;
    name_done = 1'b0;
    nchars = '0;
    tail_cnt = '0;
    qtype = '0;
    qclass = '0;
  endtask

  // Updates the parser with one byte; beats it causes land in step_beats.
  task automatic parse_dns_byte(input in_beat_t bt);
    logic [7:0] b;
    int unsigned name_idx;
    out_beat_t sb;
    b = bt.data_byte;
    step_beats.delete();
    if (pos < HEADER_BYTES) begin
      if (pos == 0) txn = {b, 8'h00};
      else if (pos == 1) txn[7:0] = b;
      else if (pos == 2 && b[7]) resp = 1'b1;
    end else if (!resp && pos != 16'hFFFF) begin
      if (!name_done) begin
        name_idx = pos - HEADER_BYTES;
        if (lab_left == 0) begin
          if (b == 0 || b > LABEL_MAX) begin
            name_done = 1'b1;
          end else begin
            lab_left = b[5:0];
            if (!first_pending && nchars < CHAR_CAP) begin
              step_beats.push_back(char_beat(DOT_CHAR));
              nchars++;
            end
            first_pending = 1'b0;
          end
        end else begin
          if (nchars < CHAR_CAP) begin
            step_beats.push_back(char_beat(b));
            nchars++;
          end
          lab_left = lab_left - 6'd1;
        end
        if (name_idx + 1 >= NAME_MAX) name_done = 1'b1;
      end else if (tail_cnt < TAIL_BYTES) begin
        if (tail_cnt < 2) qtype = {qtype[7:0], b};
        else qclass = {qclass[7:0], b};
        tail_cnt++;
      end
    end
    if (pos != 16'hFFFF) pos++;
    if (bt.last_byte) begin
      if (pos >= HEADER_BYTES && !resp) begin
        sb = '0;
        sb.kind = KIND_SUMMARY;
        sb.txn_id = txn;
        if (tail_cnt >= TAIL_BYTES) begin
          sb.query_type = qtype;
          sb.query_class = qclass;
        end
        sb.name_length = nchars;
        sb.end_of_query = 1'b1;
        step_beats.push_back(sb);
      end
      reset_parser();
    end
  endtask

  task automatic build_msg(input logic [15:0] id, input logic [7:0] flags, input int nlab,
                           input int llen, input logic [7:0] term, input logic [31:0] tail,
                           input int tail_len, input int extra, input int trunc,
                           input bit rnd);
    int len;
    msg_bytes.delete();
    msg_bytes.push_back(id[15:8]);
    msg_bytes.push_back(id[7:0]);
    msg_bytes.push_back(flags);
    for (int i = 3; i < HEADER_BYTES; i++) msg_bytes.push_back(rnd ? 8'($urandom) : 8'h00);
    for (int l = 0; l < nlab; l++) begin
      len = (rnd && llen < LABEL_MAX) ? $urandom_range(1, llen) : llen;
      msg_bytes.push_back(8'(len));
      for (int c = 0; c < len; c++)
        msg_bytes.push_back(rnd ? 8'($urandom) : 8'h61 + 8'(c % 26));
    end
    msg_bytes.push_back(term);
    for (int t = 0; t < tail_len; t++) msg_bytes.push_back(tail[31 - 8 * t -: 8]);
    for (int e = 0; e < extra; e++) msg_bytes.push_back(rnd ? 8'($urandom) : 8'hA5);
    if (trunc > 0)
      while (msg_bytes.size() > trunc) void'(msg_bytes.pop_back());
  endtask

  task automatic send_beat(input in_beat_t bt, input bit keep_pred);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= bt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_dns_byte(bt);
    if (keep_pred) foreach (step_beats[k]) qname_beats_q.push_back(step_beats[k]);
    bytes_sent++;
  endtask

  task automatic send_msg(input bit keep_pred);
    in_beat_t bt;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      bt.data_byte = msg_bytes[i];
      bt.last_byte = (i == msg_bytes.size() - 1);
      send_beat(bt, keep_pred);
    end
    msgs_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (qname_beats_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_msg();
    int r;
    logic [7:0] fl;
    r = $urandom_range(0, 99);
    fl = 8'($urandom) & 8'h7F;
    if (r < 70) begin
      build_msg(16'($urandom), fl, $urandom_range(0, 4), $urandom_range(1, 12), 8'h00,
                $urandom, 4, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0, 0, 1);
    end else if (r < 78) begin
      build_msg(16'($urandom), fl, $urandom_range(2, 4), LABEL_MAX, 8'h00, $urandom,
                $urandom_range(0, 4), 0, 0, 1);
    end else if (r < 84) begin
      build_msg(16'($urandom), fl | 8'h80, $urandom_range(0, 3), $urandom_range(1, 12),
                8'h00, $urandom, 4, 0, 0, 1);
    end else if (r < 90) begin
      build_msg(16'($urandom), fl, $urandom_range(0, 3), $urandom_range(1, 12),
                8'($urandom_range(LABEL_MAX + 1, 255)), $urandom, $urandom_range(0, 4),
                0, 0, 1);
    end else if (r < 96) begin
      build_msg(16'($urandom), fl, $urandom_range(0, 3), $urandom_range(1, 12), 8'h00,
                $urandom, 4, 0, 0, 1);
      build_msg(msg_bytes[0] << 8 | msg_bytes[1], fl, 0, 1, 8'h00, 0, 0, 0, 0, 1);
      r = $urandom_range(1, 40);
      repeat (r - 13 > 0 ? r - 13 : 0) msg_bytes.push_back(8'($urandom));
      while (msg_bytes.size() > r) void'(msg_bytes.pop_back());
    end else begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
    end
    send_msg(1'b1);
  endtask

  always @(posedge clk_i) begin : rx_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (qname_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %s", $time, fmt_beat(out_beat_o));
        mismatches++;
      end else begin
        want = qname_beats_q.pop_front();
        if (out_beat_o !== want) begin
          $display("%0t: beat mismatch\n  expected %s\n  actual   %s", $time,
                   fmt_beat(want), fmt_beat(out_beat_o));
          mismatches++;
        end else if (want.kind == KIND_SUMMARY) sums_seen++;
        else chars_seen++;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    msg_row_t  row;
    out_beat_t sb;
    int        target;
    reset_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_stall_pct = 55;
    foreach (msg_tab[i]) begin
      row = msg_tab[i];
      build_msg(row.id, row.flags, row.nlab, row.llen, row.term, row.tail, row.tail_len,
                row.extra, row.trunc, 1'b0);
      send_msg(!row.typed);
      if (row.typed && row.has_sum) begin
        sb = '0;
        sb.kind = KIND_SUMMARY;
        sb.txn_id = row.id;
        if (row.tail_len == 4) begin
          sb.query_type = row.tail[31:16];
          sb.query_class = row.tail[15:0];
        end
        sb.name_length = row.sum_len;
        sb.end_of_query = 1'b1;
        qname_beats_q.push_back(sb);
      end
    end
    drain_results();

    target = bytes_sent;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 55 : 0;
      recv_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 12 : 0;
      target += 170;
      if (ph == 2) begin
        build_msg(16'($urandom), 8'h00, 2, 8, 8'h00, $urandom, 4, 250, 0, 1);
        send_msg(1'b1);
      end
      while (bytes_sent < target) random_msg();
      drain_results();
    end

    $display("Run covered %0d bytes in %0d messages: %0d name characters, %0d summaries.",
             bytes_sent, msgs_sent, chars_seen, sums_seen);
    $display("Directed header, label, pointer and cap cases, then random queries under 3 "
             , "idle mixes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hdl/dnsqx_pkg.sv
hdl/dnsqx_front.sv
hdl/dnsqx_queue.sv
hdl/dnsqx_back.sv
hdl/dns_query_name_extractor.sv
tb/tb_dns_query_name_extractor.sv
